// ----- hdl/bvtm_pkg.sv -----
// Shared types and constants for the battery voltage trend monitor.
// Used by bvtm_div and battery_voltage_trend_monitor_core; no dependencies.
package bvtm_pkg;

	// Field widths
	localparam int PIN_W      = 12;
	localparam int GAIN_W     = 12;
	localparam int MV_W       = 14;
	localparam int THR_W      = 10;
	localparam int STABLE_W   = 8;
	localparam int SHIFT_W    = 3;
	localparam int PCT_W      = 7;
	localparam int GAIN_FRAC  = 8;
	localparam int PROD_W     = PIN_W + GAIN_W;
	localparam int SCALED_W   = PROD_W - GAIN_FRAC;

	// Percent mapping: quotient is always below 128
	localparam int QUOT_W     = 7;
	localparam int NUM_W      = MV_W + QUOT_W;
	localparam int DEN_SHIFT  = QUOT_W - 1;
	localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

	// Configuration port
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 14;

	// Defaults for top-level parameters
	localparam int FRAC_BITS_DEF   = 8;
	localparam int COUNT_WIDTH_DEF = 8;

	// Register reset values
	localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(512);
	localparam logic [MV_W-1:0]     MIN_RST    = MV_W'(2500);
	localparam logic [MV_W-1:0]     MAX_RST    = MV_W'(5000);
	localparam logic [MV_W-1:0]     EMPTY_RST  = MV_W'(3000);
	localparam logic [MV_W-1:0]     FULL_RST   = MV_W'(4200);
	localparam logic [THR_W-1:0]    THR_RST    = THR_W'(50);
	localparam logic [STABLE_W-1:0] STABLE_RST = STABLE_W'(2);
	localparam logic [SHIFT_W-1:0]  SHIFT_RST  = SHIFT_W'(2);

	// Register map
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_GAIN   = 4'd0,
		REG_MIN    = 4'd1,
		REG_MAX    = 4'd2,
		REG_EMPTY  = 4'd3,
		REG_FULL   = 4'd4,
		REG_THR    = 4'd5,
		REG_STABLE = 4'd6,
		REG_SHIFT  = 4'd7
	} cfg_reg_t;

	// Divider request and response
	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [MV_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [QUOT_W-1:0] quot;
	} div_rsp_t;

endpackage

// ----- hdl/bvtm_div.sv -----
// Restoring divider for the percent mapping, one quotient bit per cycle.
// Depends on bvtm_pkg (div_req_t, div_rsp_t, widths).
module bvtm_div import bvtm_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int STEP_W = $clog2(QUOT_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(QUOT_W - 1);

	logic [NUM_W-1:0]  rem_q;
	logic [NUM_W-1:0]  dsr_q;
	logic [QUOT_W-1:0] quot_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;
	logic              ge;

	// shared compare/subtract
	assign ge = (rem_q >= dsr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dsr_q  <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			// done pulses after the last quotient bit
			done_q <= !req.start && busy_q && (cnt_q == STEP_LAST);
			if (req.start) begin
				rem_q  <= req.num;
				dsr_q  <= NUM_W'({req.den, {DEN_SHIFT{1'b0}}});
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (ge) begin
					rem_q <= rem_q - dsr_q;
				end
				quot_q <= {quot_q[QUOT_W-2:0], ge};
				dsr_q  <= dsr_q >> 1;
				cnt_q  <= cnt_q + STEP_W'(1);
				if (cnt_q == STEP_LAST) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ----- hdl/battery_voltage_trend_monitor_core.sv -----
// Battery voltage trend monitor: scaling, clamping, percent and charging trend.
// Depends on bvtm_pkg and bvtm_div.
//
// Usage:
// - Request channel (req_valid/req_stall) carries one reading: pin_mv,
//   sample_valid, update_trend. A request is taken when req_valid is high and
//   req_stall is low. req_stall stays high while a request is in work.
// - Result channel (result_valid/result_stall) returns exactly one result per
//   request: battery_mv, range_alarm, charge_percent, charging. The result
//   register holds steady while result_valid and result_stall are high.
// - Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are always
//   ready; write only while no request is in flight. Unknown indexes are dropped.
// Sequence: the steps are scale multiply (at acceptance), clamp, two trend
// steps (only with update_trend), percent setup, the divider and a step to take
// the quotient, then hand-off; a percent of 0 or 100 skips the divider. The
// next request can be taken the cycle after hand-off, never before the last
// one is handed off. A new request is accepted while an earlier result still
// waits; if the receiver stalls, the sequencer parks in its final step until
// the result register frees up.
// Reset: registers return to their defaults; cached voltage, average, count
// and charging flag clear to zero.
module battery_voltage_trend_monitor_core import bvtm_pkg::*; #(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [PIN_W-1:0]      pin_mv,
	input  logic                  sample_valid,
	input  logic                  update_trend,
	// result channel
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [MV_W-1:0]       battery_mv,
	output logic                  range_alarm,
	output logic [PCT_W-1:0]      charge_percent,
	output logic                  charging,
	// configuration
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int SMOOTH_W = MV_W + FRAC_BITS;
	localparam int CMP_W    = (COUNT_WIDTH > STABLE_W) ? COUNT_WIDTH : STABLE_W;
	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CLAMP,
		S_TSTEP,
		S_TAPPLY,
		S_PCT,
		S_DIV,
		S_DONE
	} state_t;

	// configuration registers
	logic [GAIN_W-1:0]   gain_q;
	logic [MV_W-1:0]     min_q, max_q, empty_q, full_q;
	logic [THR_W-1:0]    thr_q;
	logic [STABLE_W-1:0] stable_q;
	logic [SHIFT_W-1:0]  shift_q;

	// sequencer and working registers
	state_t                    state_q;
	logic [PROD_W-1:0]         prod_q;
	logic                      valid_q, upd_q;
	logic signed [SMOOTH_W:0]  step_q;
	logic [PCT_W-1:0]          pct_q;

	// model state
	logic [MV_W-1:0]           cached_q;
	logic                      fault_q;
	logic [SMOOTH_W-1:0]       smooth_q;
	logic                      seeded_q;
	logic [COUNT_WIDTH-1:0]    cnt_q;
	logic                      charging_q;

	// result register
	logic                      result_valid_q;
	logic [MV_W-1:0]           battery_mv_q;
	logic                      range_alarm_q;
	logic [PCT_W-1:0]          charge_percent_q;
	logic                      charging_out_q;

	logic                      req_take;
	logic                      result_free;
	logic [SCALED_W-1:0]       scaled;
	logic [SCALED_W-1:0]       min_ext, max_ext;
	logic [SMOOTH_W-1:0]       sample_q8;
	logic signed [SMOOTH_W:0]  diff;
	logic signed [SMOOTH_W:0]  thr_sc;
	logic                      rising;
	logic [COUNT_WIDTH-1:0]    cnt_up, cnt_dn;
	logic [CMP_W-1:0]          cnt_cmp, stable_cmp;
	logic                      pct_zero, pct_full;
	logic [MV_W-1:0]           span_v;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	assign req_take    = req_valid && !req_stall;
	assign req_stall   = (state_q != S_IDLE);
	assign result_free = !result_valid_q || !result_stall;
	assign cfg_ready   = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= GAIN_RST;
			min_q    <= MIN_RST;
			max_q    <= MAX_RST;
			empty_q  <= EMPTY_RST;
			full_q   <= FULL_RST;
			thr_q    <= THR_RST;
			stable_q <= STABLE_RST;
			shift_q  <= SHIFT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
				REG_MIN:    min_q    <= cfg_data[MV_W-1:0];
				REG_MAX:    max_q    <= cfg_data[MV_W-1:0];
				REG_EMPTY:  empty_q  <= cfg_data[MV_W-1:0];
				REG_FULL:   full_q   <= cfg_data[MV_W-1:0];
				REG_THR:    thr_q    <= cfg_data[THR_W-1:0];
				REG_STABLE: stable_q <= cfg_data[STABLE_W-1:0];
				REG_SHIFT:  shift_q  <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	// scaled reading and clamp limits
	assign scaled  = prod_q[PROD_W-1:GAIN_FRAC];
	assign min_ext = SCALED_W'(min_q);
	assign max_ext = SCALED_W'(max_q);

	// trend arithmetic: difference, floor shift, threshold
	assign sample_q8 = {cached_q, {FRAC_BITS{1'b0}}};
	assign diff      = $signed({1'b0, sample_q8}) - $signed({1'b0, smooth_q});
	assign thr_sc    = $signed({{(SMOOTH_W + 1 - THR_W - FRAC_BITS){1'b0}},
		thr_q, {FRAC_BITS{1'b0}}});
	assign rising    = (step_q > thr_sc);
	assign cnt_up    = (cnt_q == COUNT_MAX) ? cnt_q : cnt_q + COUNT_WIDTH'(1);
	assign cnt_dn    = (cnt_q == '0) ? cnt_q : cnt_q - COUNT_WIDTH'(1);
	assign cnt_cmp   = CMP_W'(cnt_up);
	assign stable_cmp = CMP_W'(stable_q);

	// percent special cases and divider request
	assign pct_zero = (full_q <= empty_q) || (cached_q <= empty_q);
	assign pct_full = (cached_q >= full_q);
	assign span_v   = cached_q - empty_q;

	always_comb begin
		div_req.start = (state_q == S_PCT) && !pct_zero && !pct_full;
		div_req.num   = NUM_W'(span_v) * NUM_W'(PCT_FULL);
		div_req.den   = full_q - empty_q;
	end

	bvtm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q          <= S_IDLE;
			prod_q           <= '0;
			valid_q          <= 1'b0;
			upd_q            <= 1'b0;
			step_q           <= '0;
			pct_q            <= '0;
			cached_q         <= '0;
			fault_q          <= 1'b0;
			smooth_q         <= '0;
			seeded_q         <= 1'b0;
			cnt_q            <= '0;
			charging_q       <= 1'b0;
			result_valid_q   <= 1'b0;
			battery_mv_q     <= '0;
			range_alarm_q    <= 1'b0;
			charge_percent_q <= '0;
			charging_out_q   <= 1'b0;
		end else begin
			// S_DONE reloads the result register itself
			if (result_valid_q && !result_stall && (state_q != S_DONE)) begin
				result_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (req_take) begin
						prod_q  <= pin_mv * gain_q;
						valid_q <= sample_valid;
						upd_q   <= update_trend;
						state_q <= S_CLAMP;
					end
				end
				// range check, ceiling then floor
				S_CLAMP: begin
					if (valid_q) begin
						fault_q <= (scaled < min_ext) || (scaled > max_ext);
						if (min_ext > max_ext || scaled > max_ext) begin
							cached_q <= max_q;
						end else if (scaled < min_ext) begin
							cached_q <= min_q;
						end else begin
							cached_q <= scaled[MV_W-1:0];
						end
					end
					state_q <= upd_q ? S_TSTEP : S_PCT;
				end
				// floor division by 2^shift
				S_TSTEP: begin
					step_q  <= diff >>> shift_q;
					state_q <= S_TAPPLY;
				end
				S_TAPPLY: begin
					if (!seeded_q) begin
						smooth_q <= sample_q8;
						seeded_q <= 1'b1;
					end else begin
						smooth_q <= smooth_q + step_q[SMOOTH_W-1:0];
						if (rising) begin
							cnt_q <= cnt_up;
							if (cnt_cmp >= stable_cmp) begin
								charging_q <= 1'b1;
							end
						end else begin
							cnt_q <= cnt_dn;
							if (cnt_dn == '0) begin
								charging_q <= 1'b0;
							end
						end
					end
					state_q <= S_PCT;
				end
				S_PCT: begin
					if (pct_zero) begin
						pct_q   <= '0;
						state_q <= S_DONE;
					end else if (pct_full) begin
						pct_q   <= PCT_FULL;
						state_q <= S_DONE;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (div_rsp.done) begin
						pct_q   <= div_rsp.quot;
						state_q <= S_DONE;
					end
				end
				// hand off once the result register is free
				S_DONE: begin
					if (result_free) begin
						result_valid_q   <= 1'b1;
						battery_mv_q     <= cached_q;
						range_alarm_q    <= fault_q;
						charge_percent_q <= pct_q;
						charging_out_q   <= charging_q;
						state_q          <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign result_valid   = result_valid_q;
	assign battery_mv     = battery_mv_q;
	assign range_alarm    = range_alarm_q;
	assign charge_percent = charge_percent_q;
	assign charging       = charging_out_q;

`ifndef SYNTHESIS
	// percent never exceeds full scale
	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (charge_percent <= PCT_FULL))
		else $error("charge_percent above full scale");

	// charging is only held with a nonzero rise count
	a_charging_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		charging_q |-> (cnt_q != '0))
		else $error("charging set with zero rise count");

	// divider completes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == S_DIV))
		else $error("divider done outside divide step");

	// an accepted request blocks the next one
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_take |=> req_stall)
		else $error("request accepted without going busy");
`endif

endmodule
